FILE: sv/cps_pkg.sv
// Shared types, codes and helper functions for the connection parameter supervisor.
`default_nettype none

package cps_pkg;

    // Width of the one-shot millisecond timer.
    localparam int TIMER_BITS = 16;

    // Tolerances around the desired latency and supervision timeout.
    localparam logic signed [10:0] LAT_TOL = 11'sd25;
    localparam logic signed [16:0] TMO_TOL = 17'sd1000;

    // Event codes carried by s_op.
    typedef enum logic [2:0] {
        OP_CONNECTED    = 3'd0,
        OP_UPDATED      = 3'd1,
        OP_DISCONNECTED = 3'd2,
        OP_FORCE_UPDATE = 3'd3,
        OP_TICK         = 3'd4
    } op_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MIN_INTERVAL   = 3'd0,
        REG_MAX_INTERVAL   = 3'd1,
        REG_LATENCY        = 3'd2,
        REG_SUP_TIMEOUT    = 3'd3,
        REG_POST_CONNECT   = 3'd4,
        REG_POST_UPDATE    = 3'd5,
        REG_RETRY_DELAY    = 3'd6,
        REG_CONN_HANDLE    = 3'd7
    } reg_idx_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [11:0] desired_min_interval;
        logic [11:0] desired_max_interval;
        logic [8:0]  desired_latency;
        logic [14:0] desired_supervision_timeout;
        logic [15:0] post_connect_delay;
        logic [15:0] post_update_delay;
        logic [15:0] retry_delay;
        logic [11:0] connection_handle;
    } cfg_t;

    // One event as captured from the input channel.
    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] conn_interval;
        logic [8:0]  slave_latency;
        logic [14:0] sup_timeout;
        logic [15:0] force_delay;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic        request_update;
        logic [11:0] update_handle;
        logic        params_ok;
    } result_t;

    // Loads a 16-bit delay into the timer width, saturating if the timer is narrower.
    function automatic logic [TIMER_BITS-1:0] timer_sat(input logic [15:0] dly);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = 33'(dly);
        lim  = (33'd1 << TIMER_BITS) - 33'd1;
        if (wide > lim) begin
            timer_sat = lim[TIMER_BITS-1:0];
        end else begin
            timer_sat = wide[TIMER_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/connection_param_supervisor_top.sv
// Top level of the connection parameter supervisor.
//
// Usage: each input transaction on the s_ channel is one event for the link
// (connected, updated, disconnected, force update, or a millisecond tick).
// Every event produces exactly one result transaction on the m_ channel,
// carrying request_update, the handle for that request and the current
// params_ok judgement. Registers are written through the cfg_ channel, which
// is always ready; write them only while no event is in flight.
// Path: an accepted event is held in the input register, and its result is
// then registered in the result register, which drives the m_ channel.
// Throughput: one event per cycle while the receiver keeps m_ready high, set
// by the single evaluation stage between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults, marks the parameters good and stops the timer.
// When the receiver holds m_ready low the result stays put, the next event
// waits in the input register, and s_ready drops once that register is full.
`default_nettype none

module connection_param_supervisor_top
    import cps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [11:0] s_conn_interval,
    input  wire logic [8:0]  s_slave_latency,
    input  wire logic [14:0] s_sup_timeout,
    input  wire logic [15:0] s_force_delay,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_request_update,
    output logic [11:0]      m_update_handle,
    output logic             m_params_ok
);

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    assign s_item.op            = s_op;
    assign s_item.conn_interval = s_conn_interval;
    assign s_item.slave_latency = s_slave_latency;
    assign s_item.sup_timeout   = s_sup_timeout;
    assign s_item.force_delay   = s_force_delay;

    assign m_request_update = result.request_update;
    assign m_update_handle  = result.update_handle;
    assign m_params_ok      = result.params_ok;

    cps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cps_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    cps_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: sv/cps_cfg_regs.sv
// Configuration register file written through its own valid/ready channel.
`default_nettype none

module cps_cfg_regs
    import cps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    // The register file can always take a write.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes, masked to each register's width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.desired_min_interval        <= 12'd6;
            cfg_reg.desired_max_interval        <= 12'd3200;
            cfg_reg.desired_latency             <= 9'd0;
            cfg_reg.desired_supervision_timeout <= 15'd2000;
            cfg_reg.post_connect_delay          <= 16'd5000;
            cfg_reg.post_update_delay           <= 16'd2000;
            cfg_reg.retry_delay                 <= 16'd5000;
            cfg_reg.connection_handle           <= 12'd0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MIN_INTERVAL: cfg_reg.desired_min_interval        <= cfg_data[11:0];
                REG_MAX_INTERVAL: cfg_reg.desired_max_interval        <= cfg_data[11:0];
                REG_LATENCY:      cfg_reg.desired_latency             <= cfg_data[8:0];
                REG_SUP_TIMEOUT:  cfg_reg.desired_supervision_timeout <= cfg_data[14:0];
                REG_POST_CONNECT: cfg_reg.post_connect_delay          <= cfg_data;
                REG_POST_UPDATE:  cfg_reg.post_update_delay           <= cfg_data;
                REG_RETRY_DELAY:  cfg_reg.retry_delay                 <= cfg_data;
                REG_CONN_HANDLE:  cfg_reg.connection_handle           <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/cps_in_stage.sv
// Input register stage holding one event until the evaluation stage consumes it.
`default_nettype none

module cps_in_stage
    import cps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // A new transaction is taken when the stage is empty or drains this cycle.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cps_core.sv
// Parameter check, supervision state and timer, and the result register.
`default_nettype none

module cps_core
    import cps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    input  wire item_t item,
    output logic       take,
    output logic       m_valid,
    input  wire logic  m_ready,
    output result_t    result
);

    logic                  match_reg;
    logic                  match_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic [TIMER_BITS-1:0] left_reg;
    logic [TIMER_BITS-1:0] left_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               result_reg;
    result_t               result_next;

    logic                  iv_ok;
    logic                  lat_ok;
    logic                  tmo_ok;
    logic                  close;
    logic signed [10:0]    lat_diff;
    logic signed [16:0]    tmo_diff;
    logic                  req;
    logic                  expiring;

    // The event advances when the result register is free or being emptied.
    assign take    = item_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign result  = result_reg;

    // Window checks on the reported parameters, in signed arithmetic without wrap.
    always_comb begin
        lat_diff = $signed({2'b00, item.slave_latency}) - $signed({2'b00, cfg.desired_latency});
        tmo_diff = $signed({2'b00, item.sup_timeout})
                 - $signed({2'b00, cfg.desired_supervision_timeout});
        iv_ok  = (item.conn_interval >= cfg.desired_min_interval)
              && (item.conn_interval <= cfg.desired_max_interval);
        lat_ok = (lat_diff <= LAT_TOL) && (lat_diff >= -LAT_TOL);
        tmo_ok = (tmo_diff <= TMO_TOL) && (tmo_diff >= -TMO_TOL);
        close  = iv_ok && lat_ok && tmo_ok;
    end

    // A timer holding zero or one expires on this tick.
    assign expiring = (left_reg[TIMER_BITS-1:1] == '0);

    // Next supervision state for the event being processed.
    always_comb begin
        match_next = match_reg;
        armed_next = armed_reg;
        left_next  = left_reg;
        req        = 1'b0;
        unique case (op_t'(item.op))
            OP_CONNECTED, OP_UPDATED: begin
                match_next = close;
                if (close) begin
                    armed_next = 1'b0;
                    left_next  = '0;
                end else begin
                    armed_next = 1'b1;
                    left_next  = (op_t'(item.op) == OP_CONNECTED)
                               ? timer_sat(cfg.post_connect_delay)
                               : timer_sat(cfg.post_update_delay);
                end
            end
            OP_DISCONNECTED: begin
                armed_next = 1'b0;
                left_next  = '0;
            end
            OP_FORCE_UPDATE: begin
                match_next = 1'b0;
                armed_next = 1'b1;
                left_next  = timer_sat(item.force_delay);
            end
            OP_TICK: begin
                if (armed_reg) begin
                    if (expiring) begin
                        armed_next = 1'b0;
                        left_next  = '0;
                        if (!match_reg) begin
                            req        = 1'b1;
                            armed_next = 1'b1;
                            left_next  = timer_sat(cfg.retry_delay);
                        end
                    end else begin
                        left_next = left_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result word and output valid.
    always_comb begin
        result_next.request_update = req;
        result_next.update_handle  = req ? cfg.connection_handle : 12'd0;
        result_next.params_ok      = match_next;
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg     <= 1'b1;
            armed_reg     <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                match_reg <= match_next;
                armed_reg <= armed_next;
                left_reg  <= left_next;
            end
        end
    end

    // Result payload is loaded with each processed event.
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
